// ===== src/etf_pkg.sv =====
// ----------------------------------------------------------------------------
// etf_pkg
// Shared constants for the trial division totient block.
// ----------------------------------------------------------------------------
package etf_pkg;

    typedef logic [1:0] t_op;

    // Meaning of the division whose result is being evaluated.
    localparam t_op OP_TRIAL = 2'd0;
    localparam t_op OP_PHI   = 2'd1;
    localparam t_op OP_STRIP = 2'd2;

    localparam int FIRST_DIVISOR = 2;

endpackage

// ===== src/euler_totient_trial_division.sv =====
// ----------------------------------------------------------------------------
// euler_totient_trial_division
// Euler's totient of one unsigned integer per request, by trial division.
// ----------------------------------------------------------------------------
// Each request carries one VALUE_BITS-bit integer and yields one result, its
// totient. All arithmetic runs on one restoring divider that produces one
// quotient bit per cycle. A request takes T + M + P divisions, where T is
// the number of trial divisors tried, the last of which ends the loop, M the
// number of prime factors found inside the loop, counted with multiplicity,
// and P the number of distinct prime factors. The worst case at 31 bits is a
// large prime, about 46300 trial divisors. The next request is taken while a
// finished result still waits on the output.
// ----------------------------------------------------------------------------
module euler_totient_trial_division
    import etf_pkg::*;
#(
    parameter int VALUE_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VALUE_BITS-1:0] i_n_value,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VALUE_BITS-1:0] o_phi_value
);

    localparam int W  = VALUE_BITS;
    localparam int DW = (W + 1) / 2 + 1;
    localparam int CW = $clog2(W + 1);
    localparam logic [CW-1:0] DivSteps = CW'(W);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]    r_state,    n_state;
    t_op           r_op,       n_op;
    logic          r_final,    n_final;
    logic [W-1:0]  r_rem,      n_rem;
    logic [W-1:0]  r_phi,      n_phi;
    logic [DW-1:0] r_d,        n_d;
    logic [W-1:0]  r_div_num,  n_div_num;
    logic [W-1:0]  r_div_rem,  n_div_rem;
    logic [W-1:0]  r_div_den,  n_div_den;
    logic [CW-1:0] r_div_cnt,  n_div_cnt;
    logic          r_out_valid, n_out_valid;
    logic [W-1:0]  r_out,      n_out;

    logic [W:0]    w_trial;
    logic          w_ge;
    logic [W:0]    w_diff;
    logic [DW-1:0] w_d_inc;
    logic [W-1:0]  w_d_ext;
    logic [W-1:0]  w_d_inc_ext;

    assign w_trial     = {r_div_rem, r_div_num[W-1]};
    assign w_ge        = w_trial >= {1'b0, r_div_den};
    assign w_diff      = w_trial - {1'b0, r_div_den};
    assign w_d_inc     = r_d + 1'b1;
    assign w_d_ext     = {{(W - DW){1'b0}}, r_d};
    assign w_d_inc_ext = {{(W - DW){1'b0}}, w_d_inc};

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_final     = r_final;
        n_rem       = r_rem;
        n_phi       = r_phi;
        n_d         = r_d;
        n_div_num   = r_div_num;
        n_div_rem   = r_div_rem;
        n_div_den   = r_div_den;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_rem     = i_n_value;
                    n_phi     = i_n_value;
                    n_d       = DW'(FIRST_DIVISOR);
                    n_final   = 1'b0;
                    n_op      = OP_TRIAL;
                    n_div_num = i_n_value;
                    n_div_den = W'(FIRST_DIVISOR);
                    n_div_rem = '0;
                    n_div_cnt = DivSteps;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                n_div_num = {r_div_num[W-2:0], w_ge};
                n_div_rem = w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
                n_div_cnt = r_div_cnt - 1'b1;
                if (r_div_cnt == CW'(1)) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_div_rem = '0;
                n_div_cnt = DivSteps;
                n_state   = S_DIV;
                unique case (r_op)
                    OP_TRIAL: begin
                        if (w_d_ext > r_div_num) begin
                            if (r_rem > W'(1)) begin
                                n_final   = 1'b1;
                                n_op      = OP_PHI;
                                n_div_num = r_phi;
                                n_div_den = r_rem;
                            end else begin
                                n_state = S_DONE;
                            end
                        end else if (r_div_rem == '0) begin
                            n_rem     = r_div_num;
                            n_op      = OP_PHI;
                            n_div_num = r_phi;
                            n_div_den = w_d_ext;
                        end else begin
                            n_d       = w_d_inc;
                            n_div_num = r_rem;
                            n_div_den = w_d_inc_ext;
                        end
                    end
                    OP_PHI: begin
                        n_phi = r_phi - r_div_num;
                        if (r_final) begin
                            n_state = S_DONE;
                        end else begin
                            n_op      = OP_STRIP;
                            n_div_num = r_rem;
                            n_div_den = w_d_ext;
                        end
                    end
                    OP_STRIP: begin
                        if (r_div_rem == '0) begin
                            n_rem     = r_div_num;
                            n_div_num = r_div_num;
                            n_div_den = w_d_ext;
                        end else begin
                            n_d       = w_d_inc;
                            n_op      = OP_TRIAL;
                            n_div_num = r_rem;
                            n_div_den = w_d_inc_ext;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out       = r_phi;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_TRIAL;
            r_final     <= 1'b0;
            r_d         <= DW'(FIRST_DIVISOR);
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_final     <= n_final;
            r_d         <= n_d;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_phi     <= n_phi;
        r_div_num <= n_div_num;
        r_div_rem <= n_div_rem;
        r_div_den <= n_div_den;
        r_out     <= n_out;
    end

    assign o_stall     = r_state != S_IDLE;
    assign o_valid     = r_out_valid;
    assign o_phi_value = r_out;

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request accepted without entering the busy state");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div_cnt != '0))
        else $error("divider running with an exhausted step count");

    a_div_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div_rem < r_div_den))
        else $error("partial remainder not below the divisor");

    a_divisor_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_d >= DW'(FIRST_DIVISOR)))
        else $error("trial divisor fell below two");

endmodule
